@@ rtl/core/ffba_pkg.sv @@
// ffba_pkg: shared types, codes and defaults for the first-fit block allocator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ffba_pkg;

  localparam int MAX_BLOCKS_DEF   = 64;
  localparam int HEADER_BYTES_DEF = 16;
  localparam int ADDR_BITS_DEF    = 32;

  localparam int DATA_W     = 32;
  localparam int STATUS_W   = 3;
  localparam int CFG_IDX_W  = 1;
  // heap_base + start + header before the address mask
  localparam int ADDR_SUM_W = DATA_W + 2;

  localparam logic KIND_ALLOC   = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LIMIT = 1'b1;

  localparam logic [DATA_W-1:0] HEAP_LIMIT_RST = 32'd65536;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 3'd0,
    ST_ZERO    = 3'd1,
    ST_NOSPACE = 3'd2,
    ST_NULL    = 3'd3,
    ST_UNKNOWN = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [DATA_W-1:0] start;
    logic [DATA_W-1:0] size;
    logic              free;
  } entry_t;

  function automatic logic [ADDR_SUM_W-1:0] low_mask(input int unsigned bits);
    logic [ADDR_SUM_W-1:0] m;
    for (int k = 0; k < ADDR_SUM_W; k++) begin
      m[k] = (k < bits);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/first_fit_block_allocator.sv @@
// first_fit_block_allocator: first-fit heap block table with append at the break.
// Depends on ffba_pkg and ffba_ram (block table memory).
// Flow: zero-size, null and empty-table requests skip the scan and go straight to finish;
//   otherwise the table is scanned, and a scan stops at the first matching block.
// Words: one at a time, the next taken only once finish has issued its result; a scan is
//   paced by the single registered read port of the block table (one entry read per cycle).
// Reset: clears block count, break, heap base and handshake, resets limit; no table sweep.
`timescale 1ns / 1ps
`default_nettype none

module first_fit_block_allocator #(
  parameter int MAX_BLOCKS   = ffba_pkg::MAX_BLOCKS_DEF,
  parameter int HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF,
  parameter int ADDR_BITS    = ffba_pkg::ADDR_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic                             in_kind,
  input  wire logic [ffba_pkg::DATA_W-1:0]      in_request_bytes,
  input  wire logic [ffba_pkg::DATA_W-1:0]      in_release_address,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic      [ffba_pkg::DATA_W-1:0]      out_block_address,
  output logic      [ffba_pkg::STATUS_W-1:0]    out_status,
  input  wire logic                             cfg_we,
  input  wire logic [ffba_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ffba_pkg::DATA_W-1:0]      cfg_wdata
);

  localparam int DW    = ffba_pkg::DATA_W;
  localparam int SW    = ffba_pkg::ADDR_SUM_W;
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int ENT_W = $bits(ffba_pkg::entry_t);
  localparam logic [SW-1:0] ADDR_MASK = ffba_pkg::low_mask(ADDR_BITS);

  ffba_pkg::state_t  state_r, state_nxt;
  logic              kind_r, kind_nxt;
  logic [DW-1:0]     req_r, req_nxt;
  logic [DW-1:0]     rel_r, rel_nxt;
  logic [CNT_W-1:0]  issue_idx_r, issue_idx_nxt;
  logic [IDX_W-1:0]  ridx_r, ridx_nxt;
  logic              rvalid_r, rvalid_nxt;
  logic              hit_r, hit_nxt;
  logic [IDX_W-1:0]  hit_idx_r, hit_idx_nxt;
  ffba_pkg::entry_t  hold_r, hold_nxt;
  logic [CNT_W-1:0]  entry_count_r, entry_count_nxt;
  logic [DW-1:0]     break_offset_r, break_offset_nxt;
  logic [DW-1:0]     heap_base_r;
  logic [DW-1:0]     heap_limit_r;
  logic              out_valid_r, out_valid_nxt;
  logic [DW-1:0]     out_block_address_r, out_block_address_nxt;
  ffba_pkg::status_t out_status_r, out_status_nxt;

  logic              ram_we, ram_re;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  ffba_pkg::entry_t  ram_wentry, rd_entry;
  logic [ENT_W-1:0]  ram_rdata;

  logic              in_accept;
  logic              trivial;
  logic              issue_more;
  logic              scan_hit;
  logic              emit_ok;
  logic [SW-1:0]     scan_addr, rel_cmp;
  logic [DW-1:0]     fin_start;
  logic [SW-1:0]     fin_addr;
  logic [SW-1:0]     total, need_room;
  logic              no_space;
  logic [DW:0]       span;
  logic [DW-1:0]     break_lowered;
  logic              is_top;

  ffba_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_BLOCKS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wentry),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_entry  = ffba_pkg::entry_t'(ram_rdata);
  assign in_stall  = (state_r != ffba_pkg::S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign trivial   = (in_kind == ffba_pkg::KIND_ALLOC) ? (in_request_bytes == '0)
                                                       : (in_release_address == '0);
  assign issue_more = (issue_idx_r < entry_count_r);
  assign emit_ok    = !out_valid_r || !out_stall;

  assign scan_addr = (SW'(heap_base_r) + SW'(rd_entry.start) + SW'(HEADER_BYTES)) & ADDR_MASK;
  assign rel_cmp   = SW'(rel_r) & ADDR_MASK;
  assign scan_hit  = rvalid_r &&
                     ((kind_r == ffba_pkg::KIND_ALLOC)
                      ? (rd_entry.free && (rd_entry.size >= req_r))
                      : (scan_addr == rel_cmp));

  assign fin_start = hit_r ? hold_r.start : break_offset_r;
  assign fin_addr  = (SW'(heap_base_r) + SW'(fin_start) + SW'(HEADER_BYTES)) & ADDR_MASK;
  assign total     = SW'(HEADER_BYTES) + SW'(req_r);
  assign need_room = SW'(break_offset_r) + total;
  assign no_space  = (entry_count_r == CNT_W'(MAX_BLOCKS)) || (need_room > SW'(heap_limit_r));
  assign span      = (DW + 1)'(HEADER_BYTES) + (DW + 1)'(hold_r.size);
  assign break_lowered = ({1'b0, break_offset_r} >= span)
                         ? DW'({1'b0, break_offset_r} - span) : '0;
  assign is_top    = ((CNT_W'(hit_idx_r) + CNT_W'(1)) == entry_count_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ffba_pkg::S_IDLE: begin
        if (in_accept) begin
          state_nxt = (trivial || entry_count_r == '0) ? ffba_pkg::S_FINISH
                                                       : ffba_pkg::S_SCAN;
        end
      end
      ffba_pkg::S_SCAN: begin
        if (scan_hit || (!issue_more && !rvalid_r)) begin
          state_nxt = ffba_pkg::S_FINISH;
        end
      end
      ffba_pkg::S_FINISH: begin
        if (emit_ok) begin
          state_nxt = ffba_pkg::S_IDLE;
        end
      end
      default: state_nxt = ffba_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    kind_nxt              = kind_r;
    req_nxt               = req_r;
    rel_nxt               = rel_r;
    issue_idx_nxt         = issue_idx_r;
    ridx_nxt              = ridx_r;
    rvalid_nxt            = 1'b0;
    hit_nxt               = hit_r;
    hit_idx_nxt           = hit_idx_r;
    hold_nxt              = hold_r;
    entry_count_nxt       = entry_count_r;
    break_offset_nxt      = break_offset_r;
    out_valid_nxt         = out_valid_r && out_stall;
    out_block_address_nxt = out_block_address_r;
    out_status_nxt        = out_status_r;
    ram_we                = 1'b0;
    ram_waddr             = hit_idx_r;
    ram_wentry            = hold_r;
    ram_re                = 1'b0;
    ram_raddr             = issue_idx_r[IDX_W-1:0];

    unique case (state_r)
      ffba_pkg::S_IDLE: begin
        if (in_accept) begin
          kind_nxt      = in_kind;
          req_nxt       = in_request_bytes;
          rel_nxt       = in_release_address;
          issue_idx_nxt = '0;
          hit_nxt       = 1'b0;
        end
      end
      ffba_pkg::S_SCAN: begin
        if (scan_hit) begin
          hit_nxt     = 1'b1;
          hit_idx_nxt = ridx_r;
          hold_nxt    = rd_entry;
        end else if (issue_more) begin
          ram_re        = 1'b1;
          ridx_nxt      = issue_idx_r[IDX_W-1:0];
          rvalid_nxt    = 1'b1;
          issue_idx_nxt = issue_idx_r + CNT_W'(1);
        end
      end
      ffba_pkg::S_FINISH: begin
        if (emit_ok) begin
          out_valid_nxt         = 1'b1;
          out_block_address_nxt = '0;
          out_status_nxt        = ffba_pkg::ST_DONE;
          if (kind_r == ffba_pkg::KIND_ALLOC) begin
            priority if (req_r == '0) begin
              out_status_nxt = ffba_pkg::ST_ZERO;
            end else if (hit_r) begin
              ram_we                = 1'b1;
              ram_wentry.free       = 1'b0;
              out_block_address_nxt = fin_addr[DW-1:0];
            end else if (no_space) begin
              out_status_nxt = ffba_pkg::ST_NOSPACE;
            end else begin
              ram_we                = 1'b1;
              ram_waddr             = entry_count_r[IDX_W-1:0];
              ram_wentry.start      = break_offset_r;
              ram_wentry.size       = req_r;
              ram_wentry.free       = 1'b0;
              entry_count_nxt       = entry_count_r + CNT_W'(1);
              break_offset_nxt      = DW'(need_room);
              out_block_address_nxt = fin_addr[DW-1:0];
            end
          end else begin
            priority if (rel_r == '0) begin
              out_status_nxt = ffba_pkg::ST_NULL;
            end else if (!hit_r) begin
              out_status_nxt = ffba_pkg::ST_UNKNOWN;
            end else if (is_top) begin
              entry_count_nxt  = CNT_W'(hit_idx_r);
              break_offset_nxt = break_lowered;
            end else begin
              ram_we          = 1'b1;
              ram_wentry.free = 1'b1;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ffba_pkg::S_IDLE;
      rvalid_r       <= 1'b0;
      entry_count_r  <= '0;
      break_offset_r <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      rvalid_r       <= rvalid_nxt;
      entry_count_r  <= entry_count_nxt;
      break_offset_r <= break_offset_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_base_r  <= '0;
      heap_limit_r <= ffba_pkg::HEAP_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ffba_pkg::CFG_HEAP_BASE:  heap_base_r  <= cfg_wdata;
        ffba_pkg::CFG_HEAP_LIMIT: heap_limit_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    kind_r              <= kind_nxt;
    req_r               <= req_nxt;
    rel_r               <= rel_nxt;
    issue_idx_r         <= issue_idx_nxt;
    ridx_r              <= ridx_nxt;
    hit_r               <= hit_nxt;
    hit_idx_r           <= hit_idx_nxt;
    hold_r              <= hold_nxt;
    out_block_address_r <= out_block_address_nxt;
    out_status_r        <= out_status_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_block_address = out_block_address_r;
  assign out_status        = out_status_r;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    entry_count_r <= CNT_W'(MAX_BLOCKS))
    else $error("block count above table depth");

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("table read and write in the same cycle");

  a_rvalid_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rvalid_r |-> state_r == ffba_pkg::S_SCAN)
    else $error("read data pending outside scan");

  a_trivial_skips_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_kind == ffba_pkg::KIND_ALLOC && in_request_bytes == '0)
    |=> state_r == ffba_pkg::S_FINISH)
    else $error("zero-size request entered scan");

  a_break_moves_on_finish: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$stable(break_offset_r)) |-> $past(state_r) == ffba_pkg::S_FINISH)
    else $error("break offset changed outside finish");
`endif

endmodule

`default_nettype wire

@@ rtl/core/ffba_ram.sv @@
// ffba_ram: generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ffba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ bench/heap_result_checker.sv @@
// heap_result_checker: predicts every result of the first-fit block allocator and
// compares it with what the block puts out. Depends on ffba_pkg.
`timescale 1ns / 1ps

module heap_result_checker (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  input  wire logic                           in_stall,
  input  wire logic                           in_kind,
  input  wire logic [ffba_pkg::DATA_W-1:0]    in_request_bytes,
  input  wire logic [ffba_pkg::DATA_W-1:0]    in_release_address,
  input  wire logic                           out_valid,
  input  wire logic                           out_stall,
  input  wire logic [ffba_pkg::DATA_W-1:0]    out_block_address,
  input  wire logic [ffba_pkg::STATUS_W-1:0]  out_status,
  input  wire logic                           cfg_we,
  input  wire logic [ffba_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ffba_pkg::DATA_W-1:0]    cfg_wdata,
  output int                                  mismatch_count,
  output int                                  words_pending
);

  localparam int          DATA_W = ffba_pkg::DATA_W;
  localparam int          NBLK   = ffba_pkg::MAX_BLOCKS_DEF;
  localparam logic [31:0] HDR    = 32'(ffba_pkg::HEADER_BYTES_DEF);

  typedef struct {
    logic [DATA_W-1:0] addr;
    ffba_pkg::status_t status;
  } heap_result_t;

  heap_result_t      expected_q[$];

  logic [DATA_W-1:0] tbl_start [NBLK];
  logic [DATA_W-1:0] tbl_size  [NBLK];
  bit                tbl_free  [NBLK];
  int unsigned       blk_count;
  logic [63:0]       brk_off;
  logic [DATA_W-1:0] base_r;
  logic [DATA_W-1:0] limit_r;

  initial begin
    mismatch_count = 0;
    words_pending  = 0;
  end

  function automatic logic [DATA_W-1:0] payload_of(input int unsigned idx);
    logic [DATA_W-1:0] a;
    a = base_r + tbl_start[idx] + HDR;
    return a;
  endfunction

  task automatic predict_heap_op(input logic kind, input logic [DATA_W-1:0] req,
                                 input logic [DATA_W-1:0] rel);
    heap_result_t r;
    logic [63:0]  need;
    logic [63:0]  span;
    int           hit;
    r.addr   = '0;
    r.status = ffba_pkg::ST_DONE;
    hit      = -1;
    if (kind == ffba_pkg::KIND_ALLOC) begin
      if (req == 0) begin
        r.status = ffba_pkg::ST_ZERO;
      end else begin
        for (int i = 0; i < int'(blk_count); i++) begin
          if (tbl_free[i] && tbl_size[i] >= req) begin
            hit = i;
            break;
          end
        end
        if (hit >= 0) begin
          tbl_free[hit] = 1'b0;
          r.addr = payload_of(hit);
        end else begin
          need = 64'(HDR) + 64'(req);
          if (blk_count >= NBLK || brk_off + need > 64'(limit_r)) begin
            r.status = ffba_pkg::ST_NOSPACE;
          end else begin
            tbl_start[blk_count] = brk_off[DATA_W-1:0];
            tbl_size[blk_count]  = req;
            tbl_free[blk_count]  = 1'b0;
            r.addr    = payload_of(blk_count);
            blk_count = blk_count + 1;
            brk_off   = brk_off + need;
          end
        end
      end
    end else begin
      if (rel == 0) begin
        r.status = ffba_pkg::ST_NULL;
      end else begin
        for (int i = 0; i < int'(blk_count); i++) begin
          if (payload_of(i) == rel) begin
            hit = i;
            break;
          end
        end
        if (hit < 0) begin
          r.status = ffba_pkg::ST_UNKNOWN;
        end else if (hit + 1 == int'(blk_count)) begin
          span      = 64'(HDR) + 64'(tbl_size[hit]);
          blk_count = unsigned'(hit);
          brk_off   = (brk_off >= span) ? brk_off - span : 64'd0;
        end else begin
          tbl_free[hit] = 1'b1;
        end
      end
    end
    expected_q.push_back(r);
  endtask

  always @(posedge clk) begin
    heap_result_t e;
    if (!rst_n) begin
      blk_count = 0;
      brk_off   = '0;
      base_r    = '0;
      limit_r   = ffba_pkg::HEAP_LIMIT_RST;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == ffba_pkg::CFG_HEAP_BASE) base_r = cfg_wdata;
        else if (cfg_index == ffba_pkg::CFG_HEAP_LIMIT) limit_r = cfg_wdata;
      end
      if (in_valid && !in_stall) begin
        predict_heap_op(in_kind, in_request_bytes, in_release_address);
      end
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected word, actual block_address %h status %0d",
                   $time, out_block_address, out_status);
          mismatch_count <= mismatch_count + 1;
        end else begin
          e = expected_q.pop_front();
          if (out_block_address !== e.addr || out_status !== e.status) begin
            $display("%0t: block_address expected %h actual %h, status expected %0d actual %0d",
                     $time, e.addr, out_block_address, e.status, out_status);
            mismatch_count <= mismatch_count + 1;
          end
        end
      end
    end
    words_pending <= expected_q.size();
  end

endmodule

@@ bench/tb_first_fit_block_allocator.sv @@
// tb_first_fit_block_allocator: drives allocate/release words and register writes into
// the allocator and reports the verdict. Depends on ffba_pkg, first_fit_block_allocator and heap_result_checker.
`timescale 1ns / 1ps

module tb_first_fit_block_allocator;

  localparam int QUIET_LIMIT = 3000;
  localparam int SEG_ITEMS   = 190;
  localparam int DATA_W      = ffba_pkg::DATA_W;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic                           in_kind = ffba_pkg::KIND_ALLOC;
  logic [DATA_W-1:0]              in_request_bytes = '0;
  logic [DATA_W-1:0]              in_release_address = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [DATA_W-1:0]              out_block_address;
  logic [ffba_pkg::STATUS_W-1:0]  out_status;
  logic                           cfg_we = 1'b0;
  logic [ffba_pkg::CFG_IDX_W-1:0] cfg_index = ffba_pkg::CFG_HEAP_BASE;
  logic [DATA_W-1:0]              cfg_wdata = '0;
  int                             mismatch_count;
  int                             words_pending;

  int                   idle_pct = 0;
  int                   stall_pct = 0;
  int                   hold_seq = 0;
  int                   hold_seen = 0;
  int                   hold_left = 0;
  int                   quiet_cycles = 0;
  logic [DATA_W-1:0]    cur_base = '0;
  logic [DATA_W-1:0]    live_offsets[$];

  always #5 clk = ~clk;

  first_fit_block_allocator u_top (.*);
  heap_result_checker u_checker (.*);

  // receiver: random stall, or a long hold-off when requested
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= 300;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // remember payload offsets handed out, so releases can hit live blocks
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall && out_status == ffba_pkg::ST_DONE &&
        out_block_address != 0) begin
      live_offsets.push_back(out_block_address - cur_base);
      if (live_offsets.size() > 128) void'(live_offsets.pop_front());
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic send_word(input logic kind, input logic [DATA_W-1:0] req,
                           input logic [DATA_W-1:0] rel);
    in_valid           <= 1'b1;
    in_kind            <= kind;
    in_request_bytes   <= req;
    in_release_address <= rel;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic idle_gap();
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
  endtask

  task automatic program_heap(input logic [DATA_W-1:0] base, input logic [DATA_W-1:0] limit);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= ffba_pkg::CFG_HEAP_BASE;
    cfg_wdata <= base;
    @(posedge clk);
    cfg_index <= ffba_pkg::CFG_HEAP_LIMIT;
    cfg_wdata <= limit;
    @(posedge clk);
    cfg_we   <= 1'b0;
    cur_base = base;
  endtask

  function automatic logic [DATA_W-1:0] pick_request();
    int sel;
    sel = $urandom_range(99);
    if (sel < 4) return '0;
    if (sel < 8) return $urandom();
    if (sel < 14) return $urandom_range(65, 4096);
    return $urandom_range(1, 64);
  endfunction

  task automatic pick_release(output logic [DATA_W-1:0] rel);
    int sel;
    int k;
    sel = $urandom_range(99);
    if (sel < 5) begin
      rel = '0;
    end else if (sel < 10) begin
      rel = $urandom();
    end else if (live_offsets.size() == 0) begin
      rel = cur_base + 32'($urandom_range(16, 80));
    end else begin
      k   = $urandom_range(live_offsets.size() - 1);
      rel = cur_base + live_offsets[k];
      if (sel < 18) rel = rel + 32'($urandom_range(1, 20));
      else if (sel < 78) live_offsets.delete(k);
    end
  endtask

  initial begin
    logic [DATA_W-1:0] rel;
    int                alloc_pct;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: base 0, limit at reset value
    send_word(ffba_pkg::KIND_ALLOC, 32'd0, 32'd0);
    send_word(ffba_pkg::KIND_RELEASE, 32'd0, 32'd0);
    send_word(ffba_pkg::KIND_RELEASE, 32'd0, 32'd16);
    send_word(ffba_pkg::KIND_ALLOC, 32'd1, 32'd0);
    send_word(ffba_pkg::KIND_ALLOC, 32'hFFFF_FFFF, 32'd0);
    send_word(ffba_pkg::KIND_ALLOC, 32'd100, 32'd0);
    send_word(ffba_pkg::KIND_ALLOC, 32'd8, 32'd0);
    send_word(ffba_pkg::KIND_RELEASE, 32'd0, 32'd33);
    send_word(ffba_pkg::KIND_RELEASE, 32'd0, 32'd33);
    send_word(ffba_pkg::KIND_ALLOC, 32'd50, 32'd0);
    send_word(ffba_pkg::KIND_RELEASE, 32'd0, 32'd34);
    send_word(ffba_pkg::KIND_RELEASE, 32'd0, 32'd33);
    send_word(ffba_pkg::KIND_RELEASE, 32'd0, 32'd149);
    send_word(ffba_pkg::KIND_ALLOC, 32'd200, 32'd0);
    send_word(ffba_pkg::KIND_RELEASE, 32'd0, 32'd149);
    send_word(ffba_pkg::KIND_RELEASE, 32'd0, 32'd33);
    // limit above the break but too low for a new block, with one block still present
    program_heap(32'd0, 32'd20);
    send_word(ffba_pkg::KIND_ALLOC, 32'd4, 32'd0);
    send_word(ffba_pkg::KIND_RELEASE, 32'd0, 32'd16);
    send_word(ffba_pkg::KIND_ALLOC, 32'd4, 32'd0);
    send_word(ffba_pkg::KIND_RELEASE, 32'd0, 32'd16);
    program_heap(32'd0, 32'd0);
    send_word(ffba_pkg::KIND_ALLOC, 32'd1, 32'd0);
    // payload address wraps to zero
    program_heap(32'hFFFF_FFF0, 32'hFFFF_FFFF);
    send_word(ffba_pkg::KIND_ALLOC, 32'hFFFF_FFEF, 32'd0);
    send_word(ffba_pkg::KIND_ALLOC, 32'd1, 32'd0);
    send_word(ffba_pkg::KIND_RELEASE, 32'd0, 32'd0);
    program_heap(32'd16, 32'hFFFF_FFFF);
    send_word(ffba_pkg::KIND_RELEASE, 32'd0, 32'd32);
    program_heap(32'hFFFF_FFFF, ffba_pkg::HEAP_LIMIT_RST);
    send_word(ffba_pkg::KIND_ALLOC, 32'd1, 32'd0);
    send_word(ffba_pkg::KIND_RELEASE, 32'd0, 32'd15);
    drain_results();
    live_offsets.delete();

    for (int seg = 0; seg < 8; seg++) begin
      case (seg)
        0: program_heap(32'd0, ffba_pkg::HEAP_LIMIT_RST);
        1: program_heap(32'h0000_1000, 32'd4000);
        2: program_heap($urandom(), $urandom());
        3: program_heap(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        4: program_heap(32'hFFFF_FFF0, 32'd2000);
        5: program_heap(32'd0, 32'd0);
        6: program_heap($urandom(), ffba_pkg::HEAP_LIMIT_RST);
        default: program_heap(32'h8000_0000, 32'd600);
      endcase
      case (seg % 4)
        0: begin idle_pct = 0;  stall_pct <= 0;  end
        1: begin idle_pct = 66; stall_pct <= 0;  end
        2: begin idle_pct = 0;  stall_pct <= 66; end
        default: begin idle_pct = 34; stall_pct <= 34; end
      endcase
      if (seg == 0) hold_seq <= hold_seq + 1;
      alloc_pct = 60;
      for (int n = 0; n < SEG_ITEMS; n++) begin
        if (n % 40 == 0) alloc_pct = $urandom_range(35, 80);
        idle_gap();
        if (live_offsets.size() == 0 || $urandom_range(99) < alloc_pct) begin
          send_word(ffba_pkg::KIND_ALLOC, pick_request(), $urandom());
        end else begin
          pick_release(rel);
          send_word(ffba_pkg::KIND_RELEASE, $urandom(), rel);
        end
      end
    end

    drain_results();
    repeat (80) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
